// ===== hdl/rhsv_pkg.sv =====
package rhsv_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LOW_HUE_MAX  = 3'd0;
  localparam logic [2:0] CFG_LOW_SAT_MIN  = 3'd1;
  localparam logic [2:0] CFG_LOW_VAL_MIN  = 3'd2;
  localparam logic [2:0] CFG_HIGH_HUE_MIN = 3'd3;
  localparam logic [2:0] CFG_HIGH_SAT_MIN = 3'd4;
  localparam logic [2:0] CFG_HIGH_VAL_MIN = 3'd5;

  // Reset values of the band thresholds.
  localparam logic [8:0] RST_LOW_HUE_MAX  = 9'd26;
  localparam logic [7:0] RST_LOW_SAT_MIN  = 8'd125;
  localparam logic [7:0] RST_LOW_VAL_MIN  = 8'd107;
  localparam logic [8:0] RST_HIGH_HUE_MIN = 9'd330;
  localparam logic [7:0] RST_HIGH_SAT_MIN = 8'd199;
  localparam logic [7:0] RST_HIGH_VAL_MIN = 8'd157;

  // Hue sector offsets; a red hue below zero wraps from 360.
  localparam logic [8:0] HUE_BASE_RED   = 9'd0;
  localparam logic [8:0] HUE_BASE_GREEN = 9'd120;
  localparam logic [8:0] HUE_BASE_BLUE  = 9'd240;
  localparam logic [8:0] HUE_WRAP       = 9'd360;
  localparam logic [8:0] HUE_MAX        = 9'd359;

  // Pipeline layout: stage 1 is the front end, stage 2 forms the dividends,
  // stages 3..6 run two divider steps each, stage 7 is the output register.
  localparam int STG_DIV_FIRST = 3;
  localparam int STG_DIV_LAST  = 6;
  localparam int STG_HUE_LAST  = 5;
  localparam int STG_OUT       = 7;

  // Front-end result: maximum, delta and the hue sector decode.
  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] dlt;
    logic [7:0] diff;
    logic [8:0] base;
    logic       neg;
    logic       grey;
  } front_t;

  // Divider stage contents. Each accumulator is {partial remainder, low
  // bits}; the low bits shift out dividend bits and shift in quotient bits.
  typedef struct packed {
    logic [7:0]  mx;
    logic [7:0]  dlt;
    logic [8:0]  base;
    logic        neg;
    logic        grey;
    logic [15:0] acc_s;
    logic [15:0] acc_h;
    logic [8:0]  hue;
  } stage_t;

  // One restoring division step. The partial remainder is always below the
  // divisor on entry, so the trial value fits nine bits.
  function automatic logic [15:0] div_step(input logic [15:0] acc, input logic [7:0] dv);
    logic [8:0] trial;
    logic [8:0] diff;
    logic [15:0] res;
    trial = {acc[15:8], acc[7]};
    diff  = trial - {1'b0, dv};
    if (trial >= {1'b0, dv}) begin
      res = {diff[7:0], acc[6:0], 1'b1};
    end else begin
      res = {trial[7:0], acc[6:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// ===== hdl/rgb_to_hsv_red_classifier_core.sv =====
// RGB to HSV converter with a two-band red classifier.
// Input channel: in_valid/in_stall with in_red, in_green, in_blue (8 bits).
// Output channel: out_valid/out_stall with out_hue (0..359), out_saturation,
// out_brightness and out_is_red. A transaction completes at a clock edge with
// valid high and stall low. Every input transaction gives one result, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write thresholds only while the pipeline is empty.
// Throughput is one pixel per clock while the receiver does not stall; the two
// divisions (hue and saturation) are restoring dividers unrolled two quotient
// bits per stage, saturation over stages 3 to 6 and hue over stages 3 to 5.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// thresholds. When the receiver stalls, results stay in place and empty
// stages still fill; in_stall rises only once every stage holds a pixel.
module rgb_to_hsv_red_classifier_core
  import rhsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_hue,
  output logic [7:0] out_saturation,
  output logic [7:0] out_brightness,
  output logic       out_is_red,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [8:0] band_low_hue_max_r, band_low_hue_max_nxt;
  logic [7:0] band_low_sat_min_r, band_low_sat_min_nxt;
  logic [7:0] band_low_val_min_r, band_low_val_min_nxt;
  logic [8:0] band_high_hue_min_r, band_high_hue_min_nxt;
  logic [7:0] band_high_sat_min_r, band_high_sat_min_nxt;
  logic [7:0] band_high_val_min_r, band_high_val_min_nxt;

  logic [1:STG_OUT] vld_r, vld_nxt;
  logic [1:STG_OUT] ld;
  front_t front_r, front_nxt;
  stage_t pipe_r [2:STG_DIV_LAST];
  stage_t pipe_nxt [2:STG_DIV_LAST];
  logic [8:0] hue_r, hue_nxt;
  logic [7:0] sat_r, sat_nxt;
  logic [7:0] val_r, val_nxt;
  logic       red_r, red_nxt;

  // Configuration writes; indexes beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    band_low_hue_max_nxt  = band_low_hue_max_r;
    band_low_sat_min_nxt  = band_low_sat_min_r;
    band_low_val_min_nxt  = band_low_val_min_r;
    band_high_hue_min_nxt = band_high_hue_min_r;
    band_high_sat_min_nxt = band_high_sat_min_r;
    band_high_val_min_nxt = band_high_val_min_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOW_HUE_MAX:  band_low_hue_max_nxt  = cfg_data;
        CFG_LOW_SAT_MIN:  band_low_sat_min_nxt  = cfg_data[7:0];
        CFG_LOW_VAL_MIN:  band_low_val_min_nxt  = cfg_data[7:0];
        CFG_HIGH_HUE_MIN: band_high_hue_min_nxt = cfg_data;
        CFG_HIGH_SAT_MIN: band_high_sat_min_nxt = cfg_data[7:0];
        CFG_HIGH_VAL_MIN: band_high_val_min_nxt = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_hue_max_r  <= RST_LOW_HUE_MAX;
      band_low_sat_min_r  <= RST_LOW_SAT_MIN;
      band_low_val_min_r  <= RST_LOW_VAL_MIN;
      band_high_hue_min_r <= RST_HIGH_HUE_MIN;
      band_high_sat_min_r <= RST_HIGH_SAT_MIN;
      band_high_val_min_r <= RST_HIGH_VAL_MIN;
    end else begin
      band_low_hue_max_r  <= band_low_hue_max_nxt;
      band_low_sat_min_r  <= band_low_sat_min_nxt;
      band_low_val_min_r  <= band_low_val_min_nxt;
      band_high_hue_min_r <= band_high_hue_min_nxt;
      band_high_sat_min_r <= band_high_sat_min_nxt;
      band_high_val_min_r <= band_high_val_min_nxt;
    end
  end

  // Stage load enables: a stage loads when it is empty or its content moves on.
  always_comb begin
    ld[STG_OUT] = !vld_r[STG_OUT] || !out_stall;
    for (int k = STG_OUT - 1; k >= 1; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_stall = !ld[1];

  always_comb begin
    vld_nxt[1] = ld[1] ? in_valid : vld_r[1];
    for (int k = 2; k <= STG_OUT; k++) begin
      vld_nxt[k] = ld[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: maximum, minimum, delta and hue sector decode.
  always_comb begin
    logic [7:0] mx;
    logic [7:0] mn;
    mx = (in_red > in_green) ? in_red : in_green;
    mx = (mx > in_blue) ? mx : in_blue;
    mn = (in_red < in_green) ? in_red : in_green;
    mn = (mn < in_blue) ? mn : in_blue;
    front_nxt.mx   = mx;
    front_nxt.dlt  = mx - mn;
    front_nxt.grey = (mx == mn);
    if (in_red == mx) begin
      front_nxt.neg  = (in_green < in_blue);
      front_nxt.base = front_nxt.neg ? HUE_WRAP : HUE_BASE_RED;
      front_nxt.diff = front_nxt.neg ? (in_blue - in_green) : (in_green - in_blue);
    end else if (in_green == mx) begin
      front_nxt.neg  = (in_blue < in_red);
      front_nxt.base = HUE_BASE_GREEN;
      front_nxt.diff = front_nxt.neg ? (in_red - in_blue) : (in_blue - in_red);
    end else begin
      front_nxt.neg  = (in_red < in_green);
      front_nxt.base = HUE_BASE_BLUE;
      front_nxt.diff = front_nxt.neg ? (in_green - in_red) : (in_red - in_green);
    end
  end

  // Stage 2 forms the dividends: 255*delta over max, 60*diff over delta.
  // The hue dividend is below 64*delta, so its quotient has six bits and
  // the top eight dividend bits already sit below the divisor.
  // Stages 3..6: two divider steps per stage. The hue quotient is done after
  // stage 5; stage 6 assembles the hue from sector offset and quotient.
  always_comb begin
    logic [15:0] num_s;
    logic [13:0] num_h;
    num_s = {front_r.dlt, 8'd0} - {8'd0, front_r.dlt};
    num_h = {front_r.diff, 6'd0} - {4'd0, front_r.diff, 2'd0};
    pipe_nxt[2].mx    = front_r.mx;
    pipe_nxt[2].dlt   = front_r.dlt;
    pipe_nxt[2].base  = front_r.base;
    pipe_nxt[2].neg   = front_r.neg;
    pipe_nxt[2].grey  = front_r.grey;
    pipe_nxt[2].acc_s = num_s;
    pipe_nxt[2].acc_h = {num_h, 2'd0};
    pipe_nxt[2].hue   = '0;
    for (int k = STG_DIV_FIRST; k <= STG_DIV_LAST; k++) begin
      pipe_nxt[k] = pipe_r[k-1];
      pipe_nxt[k].acc_s = div_step(div_step(pipe_r[k-1].acc_s, pipe_r[k-1].mx),
                                   pipe_r[k-1].mx);
      if (k <= STG_HUE_LAST) begin
        pipe_nxt[k].acc_h = div_step(div_step(pipe_r[k-1].acc_h, pipe_r[k-1].dlt),
                                     pipe_r[k-1].dlt);
      end
    end
    // Falling hue terms round toward the lower hue, hence the borrow on a
    // nonzero remainder.
    if (pipe_r[STG_HUE_LAST].grey) begin
      pipe_nxt[STG_DIV_LAST].hue = '0;
    end else if (pipe_r[STG_HUE_LAST].neg) begin
      pipe_nxt[STG_DIV_LAST].hue = pipe_r[STG_HUE_LAST].base
                                 - {3'd0, pipe_r[STG_HUE_LAST].acc_h[5:0]}
                                 - {8'd0, |pipe_r[STG_HUE_LAST].acc_h[15:8]};
    end else begin
      pipe_nxt[STG_DIV_LAST].hue = pipe_r[STG_HUE_LAST].base
                                 + {3'd0, pipe_r[STG_HUE_LAST].acc_h[5:0]};
    end
  end

  // Stage 7: final saturation and the band tests.
  always_comb begin
    logic low_band;
    logic high_band;
    hue_nxt = pipe_r[STG_DIV_LAST].hue;
    sat_nxt = pipe_r[STG_DIV_LAST].grey ? 8'd0 : pipe_r[STG_DIV_LAST].acc_s[7:0];
    val_nxt = pipe_r[STG_DIV_LAST].mx;
    low_band  = (hue_nxt <= band_low_hue_max_r) && (sat_nxt >= band_low_sat_min_r) &&
                (val_nxt >= band_low_val_min_r);
    high_band = (hue_nxt >= band_high_hue_min_r) && (sat_nxt >= band_high_sat_min_r) &&
                (val_nxt >= band_high_val_min_r);
    red_nxt = low_band || high_band;
  end

  // Payload registers load with their stage; they need no reset.
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      front_r <= front_nxt;
    end
    for (int k = 2; k <= STG_DIV_LAST; k++) begin
      if (ld[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
    if (ld[STG_OUT]) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= val_nxt;
      red_r <= red_nxt;
    end
  end

  assign out_valid      = vld_r[STG_OUT];
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = val_r;
  assign out_is_red     = red_r;

  // The input is held off only when every stage holds a pixel.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled while a pipeline stage is empty");

  // Hue never leaves its range.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue <= HUE_MAX))
    else $error("hue out of range");

  // A black pixel gives zero hue and saturation.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == 8'd0) |-> (out_hue == 9'd0 && out_saturation == 8'd0))
    else $error("black pixel with nonzero hue or saturation");

  // A red result meets at least one band's brightness threshold.
  a_red_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_red) |->
      (out_brightness >= band_low_val_min_r || out_brightness >= band_high_val_min_r))
    else $error("red flag below both brightness thresholds");

endmodule
